// File: rtl/dfr_pkg.sv
// Shared types and codes for the binary GNSS frame deframer.
package dfr_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST   = 8'd181;
  localparam logic [7:0]  SYNC_SECOND_RST  = 8'd98;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd255;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
    logic [15:0] error_total;
  } result_t;

endpackage

// File: rtl/dfr_front.sv
// Frame parser: hunts sync, tracks header and checksum, classifies each byte.
module dfr_front
  import dfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       push,
  output result_t    entry
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  cur_class_r, cur_class_nxt;
  logic [7:0]  cur_id_r, cur_id_nxt;
  logic [15:0] cur_length_r, cur_length_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] fail_count_r, fail_count_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  logic [15:0] fail_inc;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [15:0] emit_index;
  logic [7:0]  emit_byte;

  assign add_a     = sum_a_r + rx_byte;
  assign add_b     = sum_b_r + add_a;
  assign count_inc = byte_count_r + 16'd1;
  assign fail_inc  = (fail_count_r == 16'hFFFF) ? fail_count_r : fail_count_r + 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    cur_class_nxt  = cur_class_r;
    cur_id_nxt     = cur_id_r;
    cur_length_nxt = cur_length_r;
    byte_count_nxt = byte_count_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    fail_count_nxt = fail_count_r;
    emit           = 1'b0;
    emit_kind      = KIND_DATA;
    emit_index     = 16'd0;
    emit_byte      = 8'd0;
    case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase_nxt = (rx_byte == cfg.sync_second) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        cur_class_nxt = rx_byte;
        sum_a_nxt     = rx_byte;
        sum_b_nxt     = rx_byte;
        phase_nxt     = PH_ID;
      end
      PH_ID: begin
        cur_id_nxt = rx_byte;
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        cur_length_nxt = {8'd0, rx_byte};
        sum_a_nxt      = add_a;
        sum_b_nxt      = add_b;
        phase_nxt      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_length_nxt = {rx_byte, cur_length_r[7:0]};
        sum_a_nxt      = add_a;
        sum_b_nxt      = add_b;
        byte_count_nxt = 16'd0;
        if ({rx_byte, cur_length_r[7:0]} >= cfg.length_limit) begin
          byte_count_nxt = byte_count_r;
          phase_nxt      = PH_SYNC1;
          emit           = 1'b1;
          emit_kind      = KIND_DROP;
        end else if ({rx_byte, cur_length_r[7:0]} != 16'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt      = add_a;
        sum_b_nxt      = add_b;
        byte_count_nxt = count_inc;
        if (count_inc == cur_length_r) phase_nxt = PH_CK_A;
        emit       = 1'b1;
        emit_kind  = KIND_DATA;
        emit_index = byte_count_r;
        emit_byte  = rx_byte;
      end
      PH_CK_A: begin
        if (rx_byte == sum_a_r) begin
          phase_nxt = PH_CK_B;
        end else begin
          phase_nxt      = PH_SYNC1;
          fail_count_nxt = fail_inc;
          emit           = 1'b1;
          emit_kind      = KIND_BAD;
        end
      end
      PH_CK_B: begin
        phase_nxt = PH_SYNC1;
        emit      = 1'b1;
        if (rx_byte == sum_b_r) begin
          emit_kind = KIND_GOOD;
        end else begin
          fail_count_nxt = fail_inc;
          emit_kind      = KIND_BAD;
        end
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase
  end

  assign push               = take & emit;
  assign entry.kind         = emit_kind;
  assign entry.msg_class    = cur_class_nxt;
  assign entry.msg_id       = cur_id_nxt;
  assign entry.payload_len  = cur_length_nxt;
  assign entry.byte_index   = emit_index;
  assign entry.payload_byte = emit_byte;
  assign entry.error_total  = fail_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SYNC1;
      cur_class_r  <= 8'd0;
      cur_id_r     <= 8'd0;
      cur_length_r <= 16'd0;
      byte_count_r <= 16'd0;
      sum_a_r      <= 8'd0;
      sum_b_r      <= 8'd0;
      fail_count_r <= 16'd0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      cur_class_r  <= cur_class_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_length_r <= cur_length_nxt;
      byte_count_r <= byte_count_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      fail_count_r <= fail_count_nxt;
    end
  end

endmodule

// File: rtl/dfr_queue.sv
// Result queue between the parser and the output channel.
module dfr_queue
  import dfr_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_entry,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output result_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  result_t         store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == FULL_COUNT);
  assign not_empty = (count_r != '0);
  assign head      = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    if (pop) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_entry;
  end

endmodule

// File: rtl/binary_gnss_frame_deframer.sv
// Top level of the binary GNSS frame deframer: registers, parser and result queue.
// One received byte is accepted per clock cycle while the queue is not full.
// The parser updates header, Fletcher sums and counters in the cycle the byte
// is accepted and writes any result into a QUEUE_DEPTH-entry queue; the head
// of that queue drives the result channel. in_stall rises only while the queue
// is full, so with the result side taking items as they come the block
// sustains one byte per cycle and a result appears in the cycle after its byte.
module binary_gnss_frame_deframer
  import dfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_msg_class,
  output logic [7:0]  out_msg_id,
  output logic [15:0] out_payload_len,
  output logic [15:0] out_byte_index,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_error_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg_r;
  logic    cfg_write;
  logic    take;
  logic    push;
  logic    full;
  result_t push_entry;
  result_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first   <= SYNC_FIRST_RST;
      cfg_r.sync_second  <= SYNC_SECOND_RST;
      cfg_r.length_limit <= LENGTH_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SYNC_FIRST:   cfg_r.sync_first   <= pwdata[7:0];
        REG_SYNC_SECOND:  cfg_r.sync_second  <= pwdata[7:0];
        REG_LENGTH_LIMIT: cfg_r.length_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SYNC_FIRST:   prdata = {24'd0, cfg_r.sync_first};
      REG_SYNC_SECOND:  prdata = {24'd0, cfg_r.sync_second};
      REG_LENGTH_LIMIT: prdata = {16'd0, cfg_r.length_limit};
      default:          prdata = 32'd0;
    endcase
  end

  assign in_stall = full;
  assign take     = in_valid & ~full;

  dfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .push    (push),
    .entry   (push_entry)
  );

  dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (out_valid & ~out_stall),
    .full       (full),
    .not_empty  (out_valid),
    .head       (head)
  );

  assign out_kind         = head.kind;
  assign out_msg_class    = head.msg_class;
  assign out_msg_id       = head.msg_id;
  assign out_payload_len  = head.payload_len;
  assign out_byte_index   = head.byte_index;
  assign out_payload_byte = head.payload_byte;
  assign out_error_total  = head.error_total;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the frame deframer: framed byte streams and register sweeps.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT1, PH_HUNT2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B
  } parse_phase_t;

  typedef enum int {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_mode_t;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int BURST_FRAMES = 8;

  class frame_checker;
    cfg_t         regs;
    parse_phase_t phase;
    logic [7:0]   cls, id, sum_a, sum_b;
    logic [15:0]  len, count, fails;
    result_t      events_q[$];
    int           errors;

    function new();
      regs.sync_first   = SYNC_FIRST_RST;
      regs.sync_second  = SYNC_SECOND_RST;
      regs.length_limit = LENGTH_LIMIT_RST;
      phase  = PH_HUNT1;
      cls    = '0;
      id     = '0;
      sum_a  = '0;
      sum_b  = '0;
      len    = '0;
      count  = '0;
      fails  = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SYNC_FIRST:   regs.sync_first = val[7:0];
        REG_SYNC_SECOND:  regs.sync_second = val[7:0];
        REG_LENGTH_LIMIT: regs.length_limit = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_SYNC_FIRST:   return {24'b0, regs.sync_first};
        REG_SYNC_SECOND:  return {24'b0, regs.sync_second};
        REG_LENGTH_LIMIT: return {16'b0, regs.length_limit};
        default:          return '0;
      endcase
    endfunction

    function void mismatch(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function string show(result_t r);
      return $sformatf("kind=%0d class=%02h id=%02h len=%0d idx=%0d byte=%02h errs=%0d",
                       r.kind, r.msg_class, r.msg_id, r.payload_len, r.byte_index,
                       r.payload_byte, r.error_total);
    endfunction

    function void add_sum(logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
    endfunction

    function void count_fail();
      if (fails != 16'hFFFF) fails++;
    endfunction

    function void push(logic [1:0] kind, logic [15:0] idx, logic [7:0] val);
      result_t r;
      r.kind         = kind;
      r.msg_class    = cls;
      r.msg_id       = id;
      r.payload_len  = len;
      r.byte_index   = idx;
      r.payload_byte = val;
      r.error_total  = fails;
      events_q.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [15:0] idx;
      case (phase)
        PH_HUNT1: begin
          if (b == regs.sync_first) phase = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase = (b == regs.sync_second) ? PH_CLASS : PH_HUNT1;
        end
        PH_CLASS: begin
          cls   = b;
          sum_a = '0;
          sum_b = '0;
          add_sum(b);
          phase = PH_ID;
        end
        PH_ID: begin
          id = b;
          add_sum(b);
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len = {8'h00, b};
          add_sum(b);
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len[15:8] = b;
          add_sum(b);
          if (len >= regs.length_limit) begin
            phase = PH_HUNT1;
            push(KIND_DROP, '0, '0);
          end else begin
            count = '0;
            phase = (len != 0) ? PH_PAYLOAD : PH_CK_A;
          end
        end
        PH_PAYLOAD: begin
          idx = count;
          add_sum(b);
          count++;
          if (count == len) phase = PH_CK_A;
          push(KIND_DATA, idx, b);
        end
        PH_CK_A: begin
          if (b == sum_a) begin
            phase = PH_CK_B;
          end else begin
            phase = PH_HUNT1;
            count_fail();
            push(KIND_BAD, '0, '0);
          end
        end
        PH_CK_B: begin
          phase = PH_HUNT1;
          if (b == sum_b) begin
            push(KIND_GOOD, '0, '0);
          end else begin
            count_fail();
            push(KIND_BAD, '0, '0);
          end
        end
        default: phase = PH_HUNT1;
      endcase
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (events_q.size() == 0) begin
        mismatch({"unexpected result ", show(got)});
        return;
      end
      want = events_q.pop_front();
      if (got.kind !== want.kind || got.msg_class !== want.msg_class ||
          got.msg_id !== want.msg_id || got.payload_len !== want.payload_len ||
          got.byte_index !== want.byte_index || got.payload_byte !== want.payload_byte ||
          got.error_total !== want.error_total)
        mismatch({"expected ", show(want), " got ", show(got)});
    endfunction

    function int pending();
      return events_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_msg_class;
  logic [7:0]  out_msg_id;
  logic [15:0] out_payload_len;
  logic [15:0] out_byte_index;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_error_total;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_checker sb;
  int stuck = 0;
  int burst_left = 0;
  int framed = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;

  binary_gnss_frame_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_msg_class    (out_msg_class),
    .out_msg_id       (out_msg_id),
    .out_payload_len  (out_payload_len),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_error_total  (out_error_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_rx_byte(in_rx_byte);
      if (out_valid && !out_stall)
        sb.check_event(result_t'({out_kind, out_msg_class, out_msg_id, out_payload_len,
                                  out_byte_index, out_payload_byte, out_error_total}));
      stuck <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : stuck + 1;
    end
  end

  initial begin
    wait (stuck >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : rx_pattern
    int pct;
    int run;
    pct = 0;
    run = 0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (run == 0) begin
          case ($urandom_range(0, 4))
            0, 1:    pct = 0;
            2:       pct = 25;
            3:       pct = 50;
            default: pct = 90;
          endcase
          run = $urandom_range(20, 300);
        end
        run--;
        out_stall <= !rx_quiet && ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!tx_quiet) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int fill,
                            input ck_mode_t mode, input int cut = -1);
    logic [7:0] hdr [4];
    logic [7:0] a, b, d;
    int i;
    a = '0;
    b = '0;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    send_byte(sb.regs.sync_first);
    send_byte(sb.regs.sync_second);
    for (i = 0; i < 4; i++) begin
      a = a + hdr[i];
      b = b + a;
      send_byte(hdr[i]);
    end
    framed += 6;
    if (len >= sb.regs.length_limit) return;
    for (i = 0; i < int'(len); i++) begin
      if (i == cut) return;
      d = (fill < 0) ? 8'($urandom) : fill[7:0];
      a = a + d;
      b = b + a;
      send_byte(d);
      framed++;
    end
    if (mode == CK_BAD_A) a = a ^ 8'($urandom_range(1, 255));
    send_byte(a);
    framed++;
    if (mode == CK_BAD_A) return;
    if (mode == CK_BAD_B) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b);
    framed++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] got, want, mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    want = sb.reg_value(idx);
    mask = (idx == REG_LENGTH_LIMIT) ? 32'h0000_FFFF : 32'h0000_00FF;
    if (idx != REG_UNUSED && (got & mask) != want)
      sb.mismatch($sformatf("register %0d read %08h, expected %08h", idx, got, want));
  endtask

  task automatic run_random(input int target, input int max_len);
    int start, r, hi;
    logic [15:0] len, lo;
    start = framed;
    while (framed - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, max_len))
                                          : 16'($urandom_range(0, 8));
        r = $urandom_range(0, 99);
        send_frame(8'($urandom), 8'($urandom), len, -1,
                   (r < 80) ? CK_GOOD : ((r < 90) ? CK_BAD_A : CK_BAD_B));
      end else if (r < 80) begin
        lo = sb.regs.length_limit;
        hi = int'(lo) + 300;
        if (hi > 65535) hi = 65535;
        send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(int'(lo), hi)), -1, CK_GOOD);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 3) == 0) ? sb.regs.sync_first : 8'($urandom));
      end else if (r < 96) begin
        send_byte(sb.regs.sync_first);
        send_byte(sb.regs.sync_second ^ 8'($urandom_range(1, 255)));
      end else begin
        len = 16'($urandom_range(2, 8));
        send_frame(8'($urandom), 8'($urandom), len, -1, CK_GOOD,
                   $urandom_range(0, int'(len) - 1));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // repeated first sync byte is consumed as a wrong second sync
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_frame(8'h00, 8'h00, 16'd0, -1, CK_GOOD);
    send_frame(8'hFF, 8'hFF, 16'd3, 255, CK_GOOD);
    send_frame(8'h01, 8'h02, 16'd2, 0, CK_GOOD);
    send_frame(8'h0A, 8'h0B, 16'd1, -1, CK_BAD_A);
    send_frame(8'h0A, 8'h0B, 16'd1, -1, CK_BAD_B);
    send_frame(8'h05, 8'h06, LENGTH_LIMIT_RST, -1, CK_GOOD);
    run_random(400, 20);
    wait_idle();

    cfg_write(REG_SYNC_FIRST, 32'h00);
    cfg_write(REG_SYNC_SECOND, 32'hFF);
    cfg_write(REG_LENGTH_LIMIT, 32'hFFFF);
    send_frame(8'h12, 8'h34, 16'hFFFF, -1, CK_GOOD);
    // hold the result side while a long payload arrives
    hold_req = 1'b1;
    send_frame(8'h55, 8'hAA, 16'd60, -1, CK_GOOD);
    run_random(350, 30);
    wait_idle();

    cfg_write(REG_SYNC_FIRST, 32'hFF);
    cfg_write(REG_SYNC_SECOND, 32'h00);
    cfg_write(REG_LENGTH_LIMIT, 32'd1);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_frame(8'h21, 8'h43, 16'd1, -1, CK_GOOD);
    send_frame(8'h21, 8'h43, 16'd0, -1, CK_GOOD);
    run_random(250, 4);
    wait_idle();

    cfg_write(REG_SYNC_FIRST, 32'h55);
    cfg_write(REG_SYNC_SECOND, 32'h55);
    cfg_write(REG_LENGTH_LIMIT, 32'd0);
    send_frame(8'h00, 8'h00, 16'd0, -1, CK_GOOD);
    run_random(150, 8);
    wait_idle();

    cfg_write(REG_SYNC_FIRST, {24'b0, SYNC_FIRST_RST});
    cfg_write(REG_SYNC_SECOND, {24'b0, SYNC_SECOND_RST});
    cfg_write(REG_LENGTH_LIMIT, 32'd300);
    run_random(300, 40);
    wait_idle();
    run_random(300, 40);
    wait_idle();

    // drive bad checksums back to back at full rate
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (BURST_FRAMES) send_frame(8'h00, 8'h00, 16'd0, -1, CK_BAD_A);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    send_frame(8'h01, 8'h02, 16'd3, -1, CK_BAD_B);
    send_frame(8'h01, 8'h02, 16'd3, -1, CK_GOOD);
    wait_idle();
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/binary_gnss_frame_deframer.sv
tb/tb.sv
